/* rtl/core/psp_pkg.sv */
// ----------------------------------------------------------------------------
// psp_pkg
// shared widths, register codes and helpers of the pixel scale/place block
// ----------------------------------------------------------------------------
package psp_pkg;

	localparam int SCREEN_SIZE_DEF = 512;
	localparam int MAX_SIDE_DEF    = 4096;

	localparam int SRC_W      = 12;
	localparam int COLOR_W    = 8;
	localparam int BRIGHT_W   = 7;
	localparam int PCT_W      = 7;
	localparam int WORD_W     = 16;
	localparam int COMP_W     = 5;
	localparam int PROD_W     = COLOR_W + BRIGHT_W;
	localparam int FRAC_W     = 16;
	// pixel quotient: src*8 stays below the smallest step, so 13 bits suffice
	localparam int QUOT_W     = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam int BRIGHT_RST = 100;
	localparam int IMG_RST    = 512;
	localparam int PCT_FULL   = 100 << FRAC_W;
	localparam int UNITY      = 1 << FRAC_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BRIGHTNESS = 2'd0,
		REG_SCALE      = 2'd1,
		REG_WIDTH      = 2'd2,
		REG_HEIGHT     = 2'd3
	} cfg_reg_t;

	function automatic int side_w(input int side_limit);
		return $clog2(side_limit + 1);
	endfunction

	function automatic int step_w(input int screen, input int side_limit);
		int a;
		// upper bound of the auto-fit step, screen rounded down to a power of two
		a = (side_limit << FRAC_W) >> ($clog2(screen + 1) - 1);
		if (a < PCT_FULL)
			a = PCT_FULL;
		return $clog2(a + 1);
	endfunction

	function automatic int ofs_w(input int side_limit);
		return side_w(side_limit) + 2;
	endfunction

	function automatic int dst_w(input int screen);
		return $clog2(screen);
	endfunction

	// floor(v*b/800) saturated to 5 bits, as floor((v*b>>5)/25)
	function automatic logic [COMP_W-1:0] comp5(input logic [PROD_W-1:0] prod);
		logic [9:0]  y;
		logic [20:0] m;
		y = prod[PROD_W-1:5];
		m = 21'(y) * 21'd1311;
		if (m[20:15] > 6'd31)
			return 5'd31;
		return m[19:15];
	endfunction

endpackage

/* rtl/core/psp_if.sv */
// ----------------------------------------------------------------------------
// psp_in_if / psp_out_if
// valid/ready channels for source pixels and placed pixels
// ----------------------------------------------------------------------------
interface psp_in_if;
	logic                         valid;
	logic                         ready;
	logic [psp_pkg::SRC_W-1:0]    src_x;
	logic [psp_pkg::SRC_W-1:0]    src_y;
	logic [psp_pkg::COLOR_W-1:0]  red;
	logic [psp_pkg::COLOR_W-1:0]  green;
	logic [psp_pkg::COLOR_W-1:0]  blue;

	modport source (output valid, src_x, src_y, red, green, blue, input ready);
	modport sink   (input valid, src_x, src_y, red, green, blue, output ready);
endinterface

interface psp_out_if #(parameter int DST_W = 9);
	logic                        valid;
	logic                        ready;
	logic [DST_W-1:0]            dest_x;
	logic [DST_W-1:0]            dest_y;
	logic [psp_pkg::WORD_W-1:0]  pixel_word;

	modport source (output valid, dest_x, dest_y, pixel_word, input ready);
	modport sink   (input valid, dest_x, dest_y, pixel_word, output ready);
endinterface

/* rtl/core/psp_cfg.sv */
// ----------------------------------------------------------------------------
// psp_cfg
// register file and serial derivation of step and centring offsets
// ----------------------------------------------------------------------------
module psp_cfg #(
	parameter int SCREEN_SIZE = psp_pkg::SCREEN_SIZE_DEF,
	parameter int MAX_SIDE    = psp_pkg::MAX_SIDE_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      cfg_we,
	input  logic [psp_pkg::CFG_IDX_W-1:0]             cfg_index,
	input  logic [psp_pkg::CFG_DATA_W-1:0]            cfg_data,
	output logic [psp_pkg::BRIGHT_W-1:0]              brightness,
	output logic [psp_pkg::side_w(MAX_SIDE)-1:0]      image_width,
	output logic [psp_pkg::side_w(MAX_SIDE)-1:0]      image_height,
	output logic [psp_pkg::step_w(SCREEN_SIZE, MAX_SIDE)-1:0] step,
	output logic signed [psp_pkg::ofs_w(MAX_SIDE)-1:0] ofs_x,
	output logic signed [psp_pkg::ofs_w(MAX_SIDE)-1:0] ofs_y,
	output logic                                      busy
);
	localparam int SIDE_W = psp_pkg::side_w(MAX_SIDE);
	localparam int STEP_W = psp_pkg::step_w(SCREEN_SIZE, MAX_SIDE);
	localparam int OFS_W  = psp_pkg::ofs_w(MAX_SIDE);
	localparam int DVW    = SIDE_W + psp_pkg::FRAC_W;
	localparam int CNT_W  = $clog2(DVW);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PREP = 5'b00010,
		ST_STEP = 5'b00100,
		ST_OFSX = 5'b01000,
		ST_OFSY = 5'b10000
	} state_t;

	state_t                        state_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [psp_pkg::BRIGHT_W-1:0]  bright_q;
	logic [psp_pkg::PCT_W-1:0]     scale_q;
	logic [SIDE_W-1:0]             width_q, height_q;
	logic [STEP_W-1:0]             step_q;
	logic signed [OFS_W-1:0]       ofsx_q, ofsy_q;
	logic [DVW-1:0]                dvd_q;
	logic [STEP_W-1:0]             rem_q, dvs_q;

	logic [STEP_W:0]               r2;
	logic                          ge;
	logic [STEP_W-1:0]             rem_nx;
	logic [DVW-1:0]                quo_nx;
	logic signed [DVW+1:0]         diff, half;
	logic [SIDE_W-1:0]             side_m;
	logic                          last;
	logic                          load;
	logic [DVW-1:0]                load_dvd;
	logic [STEP_W-1:0]             load_dvs;
	logic [SIDE_W-1:0]             wr_side;

	// one restoring division bit a cycle
	always_comb begin
		r2     = {rem_q, dvd_q[DVW-1]};
		ge     = r2 >= {1'b0, dvs_q};
		rem_nx = ge ? STEP_W'(r2 - {1'b0, dvs_q}) : r2[STEP_W-1:0];
		quo_nx = {dvd_q[DVW-2:0], ge};
		diff   = $signed((DVW+2)'(SCREEN_SIZE)) - $signed({2'b00, quo_nx});
		half   = (diff + $signed((DVW+2)'(diff[DVW+1]))) >>> 1;
		last   = (cnt_q == '0);
		side_m = (width_q > height_q) ? width_q : height_q;
		wr_side = (32'(cfg_data) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(cfg_data);
	end

	// divider operand selection for each phase
	always_comb begin
		load     = 1'b0;
		load_dvd = '0;
		load_dvs = '0;
		case (state_q)
			ST_PREP: begin
				load = 1'b1;
				if (scale_q != '0) begin
					load_dvd = DVW'(psp_pkg::PCT_FULL);
					load_dvs = STEP_W'(scale_q);
				end else if (32'(side_m) > SCREEN_SIZE) begin
					load_dvd = {side_m, {psp_pkg::FRAC_W{1'b0}}};
					load_dvs = STEP_W'(SCREEN_SIZE);
				end else begin
					load_dvd = DVW'(psp_pkg::UNITY);
					load_dvs = STEP_W'(1);
				end
			end
			ST_STEP: begin
				load     = last;
				load_dvd = {width_q, {psp_pkg::FRAC_W{1'b0}}};
				load_dvs = quo_nx[STEP_W-1:0];
			end
			ST_OFSX: begin
				load     = last;
				load_dvd = {height_q, {psp_pkg::FRAC_W{1'b0}}};
				load_dvs = step_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= load_dvd;
			dvs_q <= load_dvs;
			rem_q <= '0;
		end else begin
			dvd_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_PREP;
			cnt_q    <= CNT_W'(DVW - 1);
			bright_q <= psp_pkg::BRIGHT_W'(psp_pkg::BRIGHT_RST);
			scale_q  <= '0;
			width_q  <= SIDE_W'(psp_pkg::IMG_RST);
			height_q <= SIDE_W'(psp_pkg::IMG_RST);
			step_q   <= STEP_W'(psp_pkg::UNITY);
			ofsx_q   <= '0;
			ofsy_q   <= '0;
		end else if (cfg_we) begin
			case (psp_pkg::cfg_reg_t'(cfg_index))
				psp_pkg::REG_BRIGHTNESS: bright_q <= cfg_data[psp_pkg::BRIGHT_W-1:0];
				psp_pkg::REG_SCALE:      scale_q  <= cfg_data[psp_pkg::PCT_W-1:0];
				psp_pkg::REG_WIDTH:      width_q  <= wr_side;
				psp_pkg::REG_HEIGHT:     height_q <= wr_side;
				default: ;
			endcase
			state_q <= ST_PREP;
		end else begin
			if (load)
				cnt_q <= CNT_W'(DVW - 1);
			else
				cnt_q <= cnt_q - 1'b1;
			case (state_q)
				ST_PREP: state_q <= ST_STEP;
				ST_STEP: begin
					if (last) begin
						step_q  <= quo_nx[STEP_W-1:0];
						state_q <= ST_OFSX;
					end
				end
				ST_OFSX: begin
					if (last) begin
						ofsx_q  <= half[OFS_W-1:0];
						state_q <= ST_OFSY;
					end
				end
				ST_OFSY: begin
					if (last) begin
						ofsy_q  <= half[OFS_W-1:0];
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign brightness   = bright_q;
	assign image_width  = width_q;
	assign image_height = height_q;
	assign step         = step_q;
	assign ofs_x        = ofsx_q;
	assign ofs_y        = ofsy_q;
	assign busy         = (state_q != ST_IDLE);

endmodule

/* rtl/core/psp_pipe.sv */
// ----------------------------------------------------------------------------
// psp_pipe
// pixel pipeline: four-lane pipelined divider, colour scaling, placement
// ----------------------------------------------------------------------------
module psp_pipe #(
	parameter int SCREEN_SIZE = psp_pkg::SCREEN_SIZE_DEF,
	parameter int MAX_SIDE    = psp_pkg::MAX_SIDE_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      hold,
	input  logic [psp_pkg::BRIGHT_W-1:0]              brightness,
	input  logic [psp_pkg::side_w(MAX_SIDE)-1:0]      image_width,
	input  logic [psp_pkg::side_w(MAX_SIDE)-1:0]      image_height,
	input  logic [psp_pkg::step_w(SCREEN_SIZE, MAX_SIDE)-1:0] step,
	input  logic signed [psp_pkg::ofs_w(MAX_SIDE)-1:0] ofs_x,
	input  logic signed [psp_pkg::ofs_w(MAX_SIDE)-1:0] ofs_y,
	psp_in_if.sink                                    pix_in,
	psp_out_if.source                                 pix_out
);
	localparam int STEP_W = psp_pkg::step_w(SCREEN_SIZE, MAX_SIDE);
	localparam int OFS_W  = psp_pkg::ofs_w(MAX_SIDE);
	localparam int DST_W  = psp_pkg::dst_w(SCREEN_SIZE);
	localparam int QW     = psp_pkg::QUOT_W;
	localparam int SW     = psp_pkg::SRC_W;
	localparam int PW     = psp_pkg::PROD_W;
	localparam int CW     = psp_pkg::COMP_W;
	localparam int DW     = ((OFS_W > QW) ? OFS_W : QW) + 2;
	localparam int NL     = 4;
	localparam int LX = 0, LXM = 1, LY = 2, LYM = 3;

	logic              v_s    [0:QW];
	logic [STEP_W-1:0] rem_s  [0:QW][0:NL-1];
	logic [QW-1:0]     quo_s  [0:QW][0:NL-1];
	logic              keep_s [0:QW];
	logic              xnz_s  [0:QW];
	logic              ynz_s  [0:QW];
	logic [3*PW-1:0]   prod_s0;
	logic [3*CW-1:0]   col_s  [1:QW];
	logic              rdy    [0:QW+1];

	logic [STEP_W-1:0] rem_nx [1:QW][0:NL-1];
	logic              bit_nx [1:QW][0:NL-1];

	logic              out_valid_q;
	logic [DST_W-1:0]  dest_x_q, dest_y_q;
	logic [3*CW-1:0]   col_q;

	logic signed [DW-1:0] dx, dy;
	logic                 ok;
	logic [SW-1:0]        sxm, sym;

	// stage ready: a stage takes new data when empty or when it moves on
	assign rdy[QW+1] = !out_valid_q || pix_out.ready;
	generate
		for (genvar k = 0; k <= QW; k++) begin : g_rdy
			assign rdy[k] = !v_s[k] || rdy[k+1];
		end
	endgenerate

	assign pix_in.ready = rdy[0] && !hold;
	assign sxm = pix_in.src_x - 1'b1;
	assign sym = pix_in.src_y - 1'b1;

	// entry stage: remainders start at src<<3, colour products
	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			rem_s[0][LX]  <= STEP_W'({pix_in.src_x, 3'b000});
			rem_s[0][LXM] <= STEP_W'({sxm, 3'b000});
			rem_s[0][LY]  <= STEP_W'({pix_in.src_y, 3'b000});
			rem_s[0][LYM] <= STEP_W'({sym, 3'b000});
			for (int l = 0; l < NL; l++)
				quo_s[0][l] <= '0;
			keep_s[0] <= (32'(pix_in.src_x) < 32'(image_width)) &&
				(32'(pix_in.src_y) < 32'(image_height));
			xnz_s[0]  <= (pix_in.src_x != '0);
			ynz_s[0]  <= (pix_in.src_y != '0);
			prod_s0   <= {PW'(pix_in.green) * PW'(brightness),
				PW'(pix_in.red) * PW'(brightness),
				PW'(pix_in.blue) * PW'(brightness)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s[0] <= 1'b0;
		else if (rdy[0])
			v_s[0] <= pix_in.valid && pix_in.ready;
	end

	// one quotient bit per stage in each lane
	generate
		for (genvar k = 1; k <= QW; k++) begin : g_div
			always_comb begin
				for (int l = 0; l < NL; l++) begin
					bit_nx[k][l] = {rem_s[k-1][l], 1'b0} >= {1'b0, step};
					rem_nx[k][l] = bit_nx[k][l] ?
						STEP_W'({rem_s[k-1][l], 1'b0} - {1'b0, step}) :
						rem_s[k-1][l][STEP_W-1:0] << 1;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k]) begin
					for (int l = 0; l < NL; l++) begin
						rem_s[k][l] <= rem_nx[k][l];
						quo_s[k][l] <= {quo_s[k-1][l][QW-2:0], bit_nx[k][l]};
					end
					keep_s[k] <= keep_s[k-1];
					xnz_s[k]  <= xnz_s[k-1];
					ynz_s[k]  <= ynz_s[k-1];
				end
			end

			if (k == 1) begin : g_col
				always_ff @(posedge clk) begin
					if (rdy[k])
						col_s[k] <= {psp_pkg::comp5(prod_s0[3*PW-1:2*PW]),
							psp_pkg::comp5(prod_s0[2*PW-1:PW]),
							psp_pkg::comp5(prod_s0[PW-1:0])};
				end
			end else begin : g_colc
				always_ff @(posedge clk) begin
					if (rdy[k])
						col_s[k] <= col_s[k-1];
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					v_s[k] <= 1'b0;
				else if (rdy[k])
					v_s[k] <= v_s[k-1];
			end
		end
	endgenerate

	// placement and drop checks
	always_comb begin
		dx = $signed({{(DW-OFS_W){ofs_x[OFS_W-1]}}, ofs_x}) +
			$signed({{(DW-QW){1'b0}}, quo_s[QW][LX]});
		dy = $signed({{(DW-OFS_W){ofs_y[OFS_W-1]}}, ofs_y}) +
			$signed({{(DW-QW){1'b0}}, quo_s[QW][LY]});
		ok = keep_s[QW] &&
			!dx[DW-1] && (dx <= $signed(DW'(SCREEN_SIZE - 1))) &&
			!dy[DW-1] && (dy <= $signed(DW'(SCREEN_SIZE - 1))) &&
			!(xnz_s[QW] && (quo_s[QW][LXM] == quo_s[QW][LX])) &&
			!(ynz_s[QW] && (quo_s[QW][LYM] == quo_s[QW][LY]));
	end

	always_ff @(posedge clk) begin
		if (rdy[QW+1]) begin
			dest_x_q <= dx[DST_W-1:0];
			dest_y_q <= dy[DST_W-1:0];
			col_q    <= col_s[QW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (rdy[QW+1])
			out_valid_q <= v_s[QW] && ok;
	end

	assign pix_out.valid      = out_valid_q;
	assign pix_out.dest_x     = dest_x_q;
	assign pix_out.dest_y     = dest_y_q;
	assign pix_out.pixel_word = {col_q, 1'b1};

endmodule

/* rtl/core/pixel_scale_place_rgb555_unit.sv */
// ----------------------------------------------------------------------------
// pixel_scale_place_rgb555_unit
// nearest-neighbor placement of source pixels into a square frame, GRB555+L
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  pix_in    in   valid/ready    src_x, src_y, red, green, blue
//  pix_out   out  valid/ready    dest_x, dest_y, pixel_word
//  cfg       in   cfg_we only    cfg_index, cfg_data
//
//  one request per cycle while pix_out is not stalled and no derivation is
//  running; a request passes the entry stage, 13 divider stages and the
//  output register, the divider depth set by the 13-bit pixel quotient
//  dropped pixels leave a bubble and produce nothing on pix_out
//  after reset and after each register write the step and offsets are
//  derived serially (prepare, step, x offset, y offset), with pix_in.ready
//  low during that time
//  a stalled output only holds stages that are occupied; bubbles collapse
// ----------------------------------------------------------------------------
module pixel_scale_place_rgb555_unit #(
	parameter int SCREEN_SIZE = psp_pkg::SCREEN_SIZE_DEF,
	parameter int MAX_SIDE    = psp_pkg::MAX_SIDE_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [psp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psp_pkg::CFG_DATA_W-1:0]  cfg_data,
	psp_in_if.sink                          pix_in,
	psp_out_if.source                       pix_out
);
	localparam int SIDE_W = psp_pkg::side_w(MAX_SIDE);
	localparam int STEP_W = psp_pkg::step_w(SCREEN_SIZE, MAX_SIDE);
	localparam int OFS_W  = psp_pkg::ofs_w(MAX_SIDE);

	// derived frame mapping, stable while pixels flow
	logic [psp_pkg::BRIGHT_W-1:0] brightness;
	logic [SIDE_W-1:0]            image_width, image_height;
	logic [STEP_W-1:0]            step;
	logic signed [OFS_W-1:0]      ofs_x, ofs_y;
	logic                         busy;

	// register file plus serial divider for step and centring
	psp_cfg #(
		.SCREEN_SIZE (SCREEN_SIZE),
		.MAX_SIDE    (MAX_SIDE)
	) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.brightness   (brightness),
		.image_width  (image_width),
		.image_height (image_height),
		.step         (step),
		.ofs_x        (ofs_x),
		.ofs_y        (ofs_y),
		.busy         (busy)
	);

	// per-pixel pipeline, held off while the mapping is being derived
	psp_pipe #(
		.SCREEN_SIZE (SCREEN_SIZE),
		.MAX_SIDE    (MAX_SIDE)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.hold         (busy),
		.brightness   (brightness),
		.image_width  (image_width),
		.image_height (image_height),
		.step         (step),
		.ofs_x        (ofs_x),
		.ofs_y        (ofs_y),
		.pix_in       (pix_in),
		.pix_out      (pix_out)
	);

endmodule

/* test/psp_place_checker.sv */
// ----------------------------------------------------------------------------
// psp_place_checker
// watches the register port and both pixel channels, predicts where every
// accepted source pixel lands and what color word it carries, and compares
// each placed pixel with the oldest prediction in order
// ----------------------------------------------------------------------------
module psp_place_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [psp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [psp_pkg::CFG_DATA_W-1:0] cfg_data,
	psp_in_if                              pix_in,
	psp_out_if                             pix_out,
	output int                             errors,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SCREEN = psp_pkg::SCREEN_SIZE_DEF;
	localparam int SIDE_MAX = psp_pkg::MAX_SIDE_DEF;

	typedef struct {
		logic [8:0]                 dest_x;
		logic [8:0]                 dest_y;
		logic [psp_pkg::WORD_W-1:0] pixel_word;
	} placed_pix_t;

	placed_pix_t placed_q[$];

	int     bright_pct;
	int     scale_pct;
	int     img_w;
	int     img_h;
	longint step_fx;
	int     center_x;
	int     center_y;

	function automatic int shrink(input longint v);
		return int'((v << 16) / step_fx);
	endfunction

	function automatic void rederive();
		int m;
		m = (img_w > img_h) ? img_w : img_h;
		if (scale_pct == 0)
			step_fx = (m > SCREEN) ? ((longint'(m) << 16) / SCREEN) : 65536;
		else
			step_fx = (longint'(100) << 16) / scale_pct;
		center_x = (SCREEN - shrink(img_w)) / 2;
		center_y = (SCREEN - shrink(img_h)) / 2;
	endfunction

	// -1 when dropped on this axis
	function automatic int place_axis(input int src, input int size, input int ofs);
		int d;
		if (src >= size)
			return -1;
		d = ofs + shrink(src);
		if (d < 0 || d > SCREEN - 1)
			return -1;
		if (src > 0 && ofs + shrink(src - 1) == d)
			return -1;
		return d;
	endfunction

	function automatic logic [4:0] dim5(input int v);
		int c;
		c = ((v * 32 * bright_pct) / 100) >> 8;
		return (c > 31) ? 5'd31 : 5'(c);
	endfunction

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int dx, dy, v;
		placed_pix_t p;
		if (!arst_n) begin
			bright_pct = psp_pkg::BRIGHT_RST;
			scale_pct = 0;
			img_w = psp_pkg::IMG_RST;
			img_h = psp_pkg::IMG_RST;
			rederive();
			placed_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				v = int'(cfg_data);
				case (psp_pkg::cfg_reg_t'(cfg_index))
					psp_pkg::REG_BRIGHTNESS: bright_pct = v & 'h7f;
					psp_pkg::REG_SCALE:      scale_pct = v & 'h7f;
					psp_pkg::REG_WIDTH:      img_w = (v > SIDE_MAX) ? SIDE_MAX : v;
					psp_pkg::REG_HEIGHT:     img_h = (v > SIDE_MAX) ? SIDE_MAX : v;
					default: ;
				endcase
				rederive();
			end
			if (pix_in.valid && pix_in.ready) begin
				dy = place_axis(int'(pix_in.src_y), img_h, center_y);
				dx = (dy < 0) ? -1 : place_axis(int'(pix_in.src_x), img_w, center_x);
				if (dx >= 0) begin
					p.dest_x = 9'(dx);
					p.dest_y = 9'(dy);
					p.pixel_word = {dim5(int'(pix_in.green)), dim5(int'(pix_in.red)),
						dim5(int'(pix_in.blue)), 1'b1};
					placed_q.push_back(p);
				end
			end
			if (pix_out.valid && pix_out.ready) begin
				if (placed_q.size() == 0) begin
					report("unexpected pixel, dest_x", int'(pix_out.dest_x), -1);
				end else begin
					p = placed_q.pop_front();
					if (pix_out.dest_x !== p.dest_x)
						report("dest_x", int'(pix_out.dest_x), int'(p.dest_x));
					if (pix_out.dest_y !== p.dest_y)
						report("dest_y", int'(pix_out.dest_y), int'(p.dest_y));
					if (pix_out.pixel_word !== p.pixel_word)
						report("pixel_word", int'(pix_out.pixel_word), int'(p.pixel_word));
				end
			end
		end
		pending = placed_q.size();
	end

endmodule

/* test/tb_pixel_scale_place_rgb555_unit.sv */
// ----------------------------------------------------------------------------
// tb_pixel_scale_place_rgb555_unit
// drives source pixels through a series of scale, size and brightness
// settings with random gaps and output stalls; the checker predicts and
// compares, this module only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module tb_pixel_scale_place_rgb555_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 600000;
	// enough for the 15-stage pipe to drain dropped pixels
	localparam int DRAIN = 24;
	localparam int LONG_HOLD = 400;
	localparam int PHASES = 11;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [psp_pkg::CFG_IDX_W-1:0] cfg_index = psp_pkg::REG_BRIGHTNESS;
	logic [psp_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int errors;
	int pending;
	int cycles = 0;

	psp_in_if in_ch ();
	psp_out_if #(.DST_W(9)) out_ch ();

	pixel_scale_place_rgb555_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (in_ch),
		.pix_out   (out_ch)
	);

	psp_place_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pix_in    (in_ch),
		.pix_out   (out_ch),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("pixel_scale_place_rgb555_unit regression: fail");
			$finish;
		end
	end

	// receiver side: random stall per placed pixel, burst mode and two long holds
	bit hold_req = 1'b0;
	bit rx_burst = 1'b0;
	int rx_wait;

	always @(posedge clk or negedge arst_n) begin
		int n;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			rx_wait <= 0;
		end else if (hold_req) begin
			// long stall so the pipe fills and pix_in.ready drops
			out_ch.ready <= 1'b0;
			rx_wait <= LONG_HOLD;
		end else if (out_ch.valid && out_ch.ready) begin
			n = rx_burst ? 0 : $urandom_range(0, 13);
			rx_wait <= n;
			if (n != 0)
				out_ch.ready <= 1'b0;
		end else if (rx_wait > 1) begin
			rx_wait <= rx_wait - 1;
		end else begin
			rx_wait <= 0;
			out_ch.ready <= 1'b1;
		end
	end

	// sender state
	bit tx_burst = 1'b0;
	bit first_req = 1'b1;

	// offer one request, gap drawn before it, return once accepted
	task automatic send_pix(input int sx, input int sy, input int r, input int g, input int b);
		int gap;
		gap = tx_burst ? 0 : $urandom_range(0, 13);
		if (gap != 0 && !first_req) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		first_req = 1'b0;
		in_ch.valid <= 1'b1;
		in_ch.src_x <= 12'(sx);
		in_ch.src_y <= 12'(sy);
		in_ch.red <= 8'(r);
		in_ch.green <= 8'(g);
		in_ch.blue <= 8'(b);
		do
			@(posedge clk);
		while (!in_ch.ready);
	endtask

	// also closes a run of register writes
	task automatic go_idle();
		in_ch.valid <= 1'b0;
		cfg_we <= 1'b0;
		first_req = 1'b1;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	// write enable stays up across back-to-back writes, go_idle drops it
	task automatic write_reg(input psp_pkg::cfg_reg_t idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= psp_pkg::CFG_DATA_W'(value);
		@(posedge clk);
	endtask

	// coordinate mostly inside the current side, sometimes anywhere
	function automatic int pick_coord(input int side);
		int s;
		s = (side > 4096) ? 4096 : side;
		if (s == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 4095);
		return $urandom_range(0, s - 1);
	endfunction

	// brightness, scale, width, height per phase; extremes included
	int ph_bright [PHASES] = '{0, 127, 50, 100, 1, 73, 100, 100, 99, 64, 100};
	int ph_scale  [PHASES] = '{0, 0, 100, 127, 1, 25, 0, 0, 50, 0, 10};
	int ph_w      [PHASES] = '{4096, 8191, 300, 1, 4096, 1000, 0, 513, 37, 600, 5000};
	int ph_h      [PHASES] = '{4096, 100, 200, 1, 4096, 700, 5, 513, 4095, 2000, 0};

	initial begin
		int w, h, x0, y0, k;
		in_ch.valid <= 1'b0;
		in_ch.src_x <= '0;
		in_ch.src_y <= '0;
		in_ch.red <= '0;
		in_ch.green <= '0;
		in_ch.blue <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed at reset settings: unity step, 512 square, no offset
		tx_burst = 1'b1;
		send_pix(0, 0, 0, 0, 0);
		send_pix(511, 511, 255, 255, 255);
		send_pix(1, 1, 128, 64, 32);
		send_pix(512, 0, 255, 0, 0);
		send_pix(0, 512, 0, 255, 0);
		send_pix(4095, 4095, 0, 0, 255);
		send_pix(2048, 100, 170, 85, 170);
		send_pix(100, 2048, 85, 170, 85);
		tx_burst = 1'b0;
		send_pix(300, 200, 1, 254, 127);
		send_pix(511, 0, 255, 255, 0);
		go_idle();

		// downscale by eight: repeated rows and columns get dropped
		write_reg(psp_pkg::REG_WIDTH, 4096);
		write_reg(psp_pkg::REG_HEIGHT, 4096);
		write_reg(psp_pkg::REG_BRIGHTNESS, 127);
		write_reg(psp_pkg::REG_SCALE, 0);
		go_idle();
		send_pix(0, 0, 255, 255, 255);
		send_pix(1, 0, 255, 255, 255);
		send_pix(8, 8, 200, 100, 50);
		send_pix(9, 8, 200, 100, 50);
		send_pix(8, 9, 200, 100, 50);
		send_pix(4095, 4095, 255, 255, 255);
		send_pix(4088, 4088, 3, 7, 9);
		go_idle();

		for (int ph = 0; ph < PHASES; ph++) begin
			write_reg(psp_pkg::REG_BRIGHTNESS, ph_bright[ph]);
			write_reg(psp_pkg::REG_SCALE, ph_scale[ph]);
			write_reg(psp_pkg::REG_WIDTH, ph_w[ph]);
			write_reg(psp_pkg::REG_HEIGHT, ph_h[ph]);
			go_idle();
			w = ph_w[ph];
			h = ph_h[ph];
			tx_burst = (ph % 3 == 2);
			rx_burst = (ph % 4 == 3);
			if (ph == 3 || ph == 9) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			// raster runs along rows, then scattered pixels
			for (int i = 0; i < 50; i++) begin
				if (i % 10 == 0) begin
					x0 = pick_coord(w);
					y0 = pick_coord(h);
				end
				k = i % 10;
				send_pix(x0 + k, y0 + (i / 10) % 2, $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255));
			end
			for (int i = 0; i < 40; i++)
				send_pix(pick_coord(w), pick_coord(h), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255));
			go_idle();
		end

		if (errors == 0)
			$display("pixel_scale_place_rgb555_unit regression: pass");
		else
			$display("pixel_scale_place_rgb555_unit regression: fail");
		$finish;
	end

endmodule

/* pixel_scale_place_rgb555_unit.f */
rtl/core/psp_pkg.sv
rtl/core/psp_if.sv
rtl/core/psp_cfg.sv
rtl/core/psp_pipe.sv
rtl/core/pixel_scale_place_rgb555_unit.sv
test/psp_place_checker.sv
test/tb_pixel_scale_place_rgb555_unit.sv
